// ===== hdl/vmdpf_pkg.sv =====
`timescale 1ns / 1ps
package vmdpf_pkg;

  localparam int unsigned FracBits = 24;

  localparam logic [1:0] StatStored  = 2'd0;
  localparam logic [1:0] StatFull    = 2'd1;
  localparam logic [1:0] StatOutside = 2'd2;
  localparam logic [1:0] StatNone    = 2'd3;

  localparam logic [2:0] RegVoxel   = 3'd0;
  localparam logic [2:0] RegInv     = 3'd1;
  localparam logic [2:0] RegRadius  = 3'd2;
  localparam logic [2:0] RegOriginX = 3'd3;
  localparam logic [2:0] RegOriginY = 3'd4;
  localparam logic [2:0] RegOriginZ = 3'd5;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StCellMul,
    StCellFix,
    StDispatch,
    StInsRead,
    StInsWrite,
    StNearAddr,
    StNearCnt,
    StNearSlot,
    StNearChk,
    StHalf,
    StOccAddr,
    StOccChk,
    StOut
  } state_e;

endpackage

// ===== hdl/vmdpf_if.sv =====
`timescale 1ns / 1ps
interface vmdpf_in_if #(parameter int CoordBits = 24);
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic signed [CoordBits-1:0] pos_x;
  logic signed [CoordBits-1:0] pos_y;
  logic signed [CoordBits-1:0] pos_z;
  logic                        coords_valid;
  logic                        end_of_scan;
  modport source (output valid, mode, pos_x, pos_y, pos_z, coords_valid, end_of_scan,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, pos_z, coords_valid, end_of_scan,
                output ready);
endinterface

interface vmdpf_out_if;
  logic        valid;
  logic        ready;
  logic        keep_point;
  logic [31:0] drops_in_scan;
  logic [1:0]  insert_status;
  logic        scan_done;
  modport source (output valid, keep_point, drops_in_scan, insert_status, scan_done,
                  input ready);
  modport sink (input valid, keep_point, drops_in_scan, insert_status, scan_done,
                output ready);
endinterface

// ===== hdl/voxel_map_dynamic_point_filter_unit.sv =====
`timescale 1ns / 1ps
// An insert word stores the point in its cell. A classify word checks the stored points of
// the 3x3x3 neighbor cells, then the grid cells of the occupancy cube (up to 15^3 cells).
// One word is in flight at a time; input is ready again the cycle after the result word is
// taken. Reset restores the register defaults and sweeps the cell memory before the first
// word is accepted.
module voxel_map_dynamic_point_filter_unit
  import vmdpf_pkg::*;
#(
  parameter int GRID_DIM       = 32,
  parameter int SLOTS_PER_CELL = 4,
  parameter int MAX_HALF_RANGE = 7,
  parameter int COORD_BITS     = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vmdpf_in_if.sink    in_if,
  vmdpf_out_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int GB = $clog2(GRID_DIM);
  localparam int CellBits = 3 * GB;
  localparam int Cells = 1 << CellBits;
  localparam int SB = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int CB = $clog2(SLOTS_PER_CELL + 1);
  localparam int SlotAddrBits = CellBits + SB;
  localparam int SlotDepth = 1 << SlotAddrBits;
  localparam int HB = $clog2(MAX_HALF_RANGE + 1) + 1;
  localparam int KB = COORD_BITS + 2;
  localparam int DB = COORD_BITS + 2;
  localparam int PB = COORD_BITS + 26;

  logic [15:0]        voxel_q;
  logic [24:0]        inv_q;
  logic [15:0]        radius_q;
  logic signed [23:0] org_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voxel_q  <= 16'd100;
      inv_q    <= 25'd167772;
      radius_q <= 16'd500;
      org_q[0] <= -24'sd16;
      org_q[1] <= -24'sd16;
      org_q[2] <= -24'sd16;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        RegVoxel:   voxel_q  <= pwdata[15:0];
        RegInv:     inv_q    <= pwdata[24:0];
        RegRadius:  radius_q <= pwdata[15:0];
        RegOriginX: org_q[0] <= pwdata[23:0];
        RegOriginY: org_q[1] <= pwdata[23:0];
        RegOriginZ: org_q[2] <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[4:2])
      RegVoxel:   prdata = {16'd0, voxel_q};
      RegInv:     prdata = {7'd0, inv_q};
      RegRadius:  prdata = {16'd0, radius_q};
      RegOriginX: prdata = {8'd0, org_q[0]};
      RegOriginY: prdata = {8'd0, org_q[1]};
      RegOriginZ: prdata = {8'd0, org_q[2]};
      default:    prdata = 32'd0;
    endcase
  end

  state_e state_q, state_d;
  logic signed [COORD_BITS-1:0] pos_q [3];
  logic mode_q, cv_q, eos_q;
  logic [1:0] axis_q, axis_d;
  logic signed [PB-1:0] prod_q;
  logic signed [KB-1:0] cellk_q [3];
  logic signed [2:0] dn_q [3];
  logic signed [HB-1:0] dh_q [3];
  logic [HB-1:0] half_q;
  logic [CB-1:0] cnt_q;
  logic [SB-1:0] slot_q;
  logic [CellBits-1:0] cidx_q;
  logic [CellBits-1:0] clr_q;
  logic map_q;
  logic [31:0] drops_q;
  logic keep_q;
  logic [1:0] stat_q;
  logic ovalid_q;

  // Cell memory: occupied bit and point count, one port.
  logic [CB:0]         cell_mem [Cells];
  logic [CellBits-1:0] cell_addr;
  logic                cell_we;
  logic [CB:0]         cell_wdata;
  logic [CB:0]         cell_rdata_q;
  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_addr] <= cell_wdata;
    cell_rdata_q <= cell_mem[cell_addr];
  end

  logic [3*COORD_BITS-1:0] slot_mem [SlotDepth];
  logic [SlotAddrBits-1:0] slot_addr;
  logic                    slot_we;
  logic [3*COORD_BITS-1:0] slot_rdata_q;
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_addr] <= {pos_q[0], pos_q[1], pos_q[2]};
    slot_rdata_q <= slot_mem[slot_addr];
  end

  // Shared multiplier: position times inverse voxel, or radius times inverse.
  logic signed [COORD_BITS:0] mul_a;
  logic signed [25:0]         mul_b;
  always_comb begin
    if (state_q == StHalf) mul_a = $signed((COORD_BITS+1)'(radius_q));
    else mul_a = {pos_q[axis_q][COORD_BITS-1], pos_q[axis_q]};
  end
  assign mul_b = $signed({1'b0, inv_q});
  logic signed [PB-1:0] mul_p;
  assign mul_p = PB'(mul_a) * PB'(mul_b);

  logic signed [KB-1:0] floor_k;
  assign floor_k = KB'(prod_q >>> FracBits);

  // Neighbor cell address from offsets.
  logic signed [KB+1:0] lc [3];
  logic inside_c;
  logic [CellBits-1:0] lin_c;
  always_comb begin
    inside_c = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lc[i] = (KB+2)'(cellk_q[i]) - (KB+2)'(org_q[i]);
      if (state_q == StOccAddr || state_q == StOccChk) lc[i] = lc[i] + (KB+2)'(dh_q[i]);
      else lc[i] = lc[i] + (KB+2)'(dn_q[i]);
      if (lc[i] < 0 || lc[i] >= GRID_DIM) inside_c = 1'b0;
    end
    lin_c = {lc[0][GB-1:0], lc[1][GB-1:0], lc[2][GB-1:0]};
  end

  // Distance check against one slot.
  logic signed [DB-1:0] dd [3];
  logic [DB-1:0] ad [3];
  logic [33:0] sq [3];
  logic far_c;
  logic [35:0] dist2;
  logic [31:0] vsq;
  always_comb begin
    far_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dd[i] = DB'(pos_q[i]) -
        DB'($signed(slot_rdata_q[(2-i)*COORD_BITS +: COORD_BITS]));
      ad[i] = dd[i][DB-1] ? DB'(-dd[i]) : DB'(dd[i]);
      if (ad[i] > DB'(voxel_q)) far_c = 1'b1;
      sq[i] = 34'(ad[i][16:0]) * 34'(ad[i][16:0]);
    end
    dist2 = 36'(sq[0]) + 36'(sq[1]) + 36'(sq[2]);
  end
  assign vsq = 32'(voxel_q) * 32'(voxel_q);
  logic hit_c;
  assign hit_c = !far_c && (dist2 <= 36'(vsq));

  logic last_n, last_h;
  assign last_n = dn_q[0] == 3'sd1 && dn_q[1] == 3'sd1 && dn_q[2] == 3'sd1;
  assign last_h = dh_q[0] == $signed(half_q) && dh_q[1] == $signed(half_q) &&
                  dh_q[2] == $signed(half_q);

  logic outside_ins;
  logic [CellBits-1:0] lin_ins;
  always_comb begin
    outside_ins = !inside_c;
    lin_ins = lin_c;
  end

  assign in_if.ready = (state_q == StIdle) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.keep_point = keep_q;
  assign out_if.drops_in_scan = mode_q ? drops_q : 32'd0;
  assign out_if.insert_status = stat_q;
  assign out_if.scan_done = eos_q & mode_q;

  logic [CB-1:0] ccount;
  assign ccount = cell_rdata_q[CB-1:0];

  always_comb begin
    state_d = state_q;
    axis_d = axis_q;
    cell_we = 1'b0;
    cell_addr = cidx_q;
    cell_wdata = '0;
    slot_we = 1'b0;
    slot_addr = {cidx_q, slot_q};
    unique case (state_q)
      StClear: begin
        cell_we = 1'b1;
        cell_addr = clr_q;
        if (clr_q == CellBits'(Cells - 1)) state_d = StIdle;
      end
      StIdle: if (in_if.valid && in_if.ready) state_d = StCellMul;
      StCellMul: state_d = StCellFix;
      StCellFix: begin
        if (axis_q == 2'd2) begin
          axis_d = 2'd0;
          state_d = StDispatch;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = StCellMul;
        end
      end
      StDispatch: begin
        if (!mode_q) begin
          if (!cv_q) state_d = StOut;
          else if (outside_ins) state_d = StOut;
          else state_d = StInsRead;
        end else if (!cv_q || !map_q) state_d = StOut;
        else state_d = StNearAddr;
        cell_addr = lin_ins;
      end
      StInsRead: state_d = StInsWrite;
      StInsWrite: begin
        cell_we = 1'b1;
        if (ccount < CB'(SLOTS_PER_CELL)) begin
          cell_wdata = {1'b1, ccount + CB'(1)};
          slot_we = 1'b1;
          slot_addr = {cidx_q, ccount[SB-1:0]};
        end else cell_wdata = {1'b1, ccount};
        state_d = StOut;
      end
      StNearAddr: begin
        cell_addr = lin_c;
        if (inside_c) state_d = StNearCnt;
        else if (last_n) state_d = StHalf;
      end
      StNearCnt: begin
        if (ccount == '0) state_d = last_n ? StHalf : StNearAddr;
        else state_d = StNearSlot;
      end
      StNearSlot: state_d = StNearChk;
      StNearChk: begin
        if (hit_c) state_d = StOut;
        else if (CB'(slot_q) + CB'(1) < cnt_q) state_d = StNearSlot;
        else if (last_n) state_d = StHalf;
        else state_d = StNearAddr;
      end
      StHalf: state_d = StOccAddr;
      StOccAddr: begin
        cell_addr = lin_c;
        if (inside_c) state_d = StOccChk;
        else if (last_h) state_d = StOut;
      end
      StOccChk: begin
        if (cell_rdata_q[CB] || last_h) state_d = StOut;
        else state_d = StOccAddr;
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  function automatic logic signed [2:0] nstep_lo(input logic signed [2:0] v);
    return (v == 3'sd1) ? -3'sd1 : v + 3'sd1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      axis_q <= '0;
      map_q <= 1'b0;
      drops_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q <= axis_d;
      if (state_q == StClear) clr_q <= clr_q + CellBits'(1);
      if (out_if.valid && out_if.ready) begin
        ovalid_q <= 1'b0;
        if (mode_q && eos_q) drops_q <= '0;
      end
      if (state_q == StInsWrite) map_q <= 1'b1;
      if (state_q == StOccChk && cell_rdata_q[CB] && drops_q != '1) drops_q <= drops_q + 1'b1;
      if (state_q == StOut) ovalid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (in_if.valid && in_if.ready) begin
          pos_q[0] <= in_if.pos_x;
          pos_q[1] <= in_if.pos_y;
          pos_q[2] <= in_if.pos_z;
          mode_q <= in_if.mode;
          cv_q <= in_if.coords_valid;
          eos_q <= in_if.end_of_scan;
          for (int i = 0; i < 3; i++) begin
            dn_q[i] <= '0;
          end
        end
      end
      StCellMul: prod_q <= mul_p;
      StCellFix: cellk_q[axis_q] <= floor_k;
      StDispatch: begin
        cidx_q <= lin_c;
        keep_q <= mode_q;
        stat_q <= mode_q ? StatNone : (!cv_q ? StatNone : (outside_ins ? StatOutside : StatNone));
        for (int i = 0; i < 3; i++) dn_q[i] <= -3'sd1;
      end
      StInsWrite: stat_q <= (ccount < CB'(SLOTS_PER_CELL)) ? StatStored : StatFull;
      StNearAddr: begin
        cidx_q <= lin_c;
        slot_q <= '0;
      end
      StNearCnt: begin
        cnt_q <= (ccount > CB'(SLOTS_PER_CELL)) ? CB'(SLOTS_PER_CELL) : ccount;
        if (ccount == '0) begin
          dn_q[2] <= nstep_lo(dn_q[2]);
          if (dn_q[2] == 3'sd1) begin
            dn_q[1] <= nstep_lo(dn_q[1]);
            if (dn_q[1] == 3'sd1) dn_q[0] <= nstep_lo(dn_q[0]);
          end
        end
      end
      StNearChk: begin
        if (!hit_c) begin
          if (CB'(slot_q) + CB'(1) < cnt_q) slot_q <= slot_q + 1'b1;
          else begin
            dn_q[2] <= nstep_lo(dn_q[2]);
            if (dn_q[2] == 3'sd1) begin
              dn_q[1] <= nstep_lo(dn_q[1]);
              if (dn_q[1] == 3'sd1) dn_q[0] <= nstep_lo(dn_q[0]);
            end
          end
        end
      end
      StHalf: begin
        if (((mul_p + (1 <<< FracBits) - 1) >>> FracBits) >= MAX_HALF_RANGE)
          half_q <= HB'(MAX_HALF_RANGE);
        else if (((mul_p + (1 <<< FracBits) - 1) >>> FracBits) < 2) half_q <= HB'(2);
        else half_q <= HB'((mul_p + (1 <<< FracBits) - 1) >>> FracBits);
      end
      default: ;
    endcase
    if (state_q == StHalf) begin
      if (((mul_p + (1 <<< FracBits) - 1) >>> FracBits) >= MAX_HALF_RANGE)
        for (int i = 0; i < 3; i++) dh_q[i] <= -$signed(HB'(MAX_HALF_RANGE));
      else if (((mul_p + (1 <<< FracBits) - 1) >>> FracBits) < 2)
        for (int i = 0; i < 3; i++) dh_q[i] <= -$signed(HB'(2));
      else
        for (int i = 0; i < 3; i++)
          dh_q[i] <= -$signed(HB'((mul_p + (1 <<< FracBits) - 1) >>> FracBits));
    end
    if (state_q == StNearAddr && !inside_c) begin
      dn_q[2] <= nstep_lo(dn_q[2]);
      if (dn_q[2] == 3'sd1) begin
        dn_q[1] <= nstep_lo(dn_q[1]);
        if (dn_q[1] == 3'sd1) dn_q[0] <= nstep_lo(dn_q[0]);
      end
    end
    if ((state_q == StOccAddr && !inside_c) || (state_q == StOccChk && !cell_rdata_q[CB])) begin
      if (dh_q[2] == $signed(half_q)) begin
        dh_q[2] <= -$signed(half_q);
        if (dh_q[1] == $signed(half_q)) begin
          dh_q[1] <= -$signed(half_q);
          dh_q[0] <= dh_q[0] + 1'b1;
        end else dh_q[1] <= dh_q[1] + 1'b1;
      end else dh_q[2] <= dh_q[2] + 1'b1;
    end
    if (state_q == StOccChk && cell_rdata_q[CB]) keep_q <= 1'b0;
  end

endmodule

// ===== hdl/vmdpf_checker.sv =====
`timescale 1ns / 1ps
module vmdpf_checker
  import vmdpf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        keep_point,
  input logic [1:0]  insert_status,
  input logic [31:0] drops_in_scan,
  input logic        scan_done
);

  a_no_ready_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input ready while a word waits");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(drops_in_scan) && $stable(keep_point) &&
      $stable(insert_status) && $stable(scan_done))
    else $error("stalled output word changed");

  a_insert_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && insert_status != StatNone |-> !keep_point && drops_in_scan == 32'd0)
    else $error("insert word with a verdict or a count");

  a_done_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && scan_done |-> insert_status == StatNone)
    else $error("scan end flagged on an insert word");

endmodule

bind voxel_map_dynamic_point_filter_unit vmdpf_checker u_vmdpf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .keep_point(out_if.keep_point),
  .insert_status(out_if.insert_status), .drops_in_scan(out_if.drops_in_scan),
  .scan_done(out_if.scan_done));

// ===== tb/voxel_map_dynamic_point_filter_checker.sv =====
`timescale 1ns / 1ps
module voxel_map_dynamic_point_filter_checker
  import vmdpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  vmdpf_in_if         in_mon,
  vmdpf_out_if        out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          words_pending
);

  localparam int Dim = 32;
  localparam int Slots = 4;
  localparam int MaxHalf = 7;

  typedef struct packed {
    logic        keep;
    logic [31:0] drops;
    logic [1:0]  status;
    logic        done;
  } verdict_t;

  verdict_t verdict_q[$];

  longint voxel_mm, inv_scaled, radius_mm, org_x, org_y, org_z;
  bit          occupied[Dim*Dim*Dim];
  int unsigned fill[Dim*Dim*Dim];
  longint      slot_x[Dim*Dim*Dim*Slots];
  longint      slot_y[Dim*Dim*Dim*Slots];
  longint      slot_z[Dim*Dim*Dim*Slots];
  bit          map_nonempty;
  logic [31:0] scan_drops;

  function automatic longint to_cell(longint p);
    longint prod;
    prod = p * inv_scaled;
    return prod >>> FracBits;
  endfunction

  function automatic int grid_index(longint kx, longint ky, longint kz);
    longint lx, ly, lz;
    lx = kx - org_x;
    ly = ky - org_y;
    lz = kz - org_z;
    if (lx < 0 || lx >= Dim || ly < 0 || ly >= Dim || lz < 0 || lz >= Dim) return -1;
    return int'((lx * Dim + ly) * Dim + lz);
  endfunction

  function automatic longint absval(longint d);
    return (d < 0) ? -d : d;
  endfunction

  function automatic bit static_match(longint x, longint y, longint z,
                                      longint kx, longint ky, longint kz);
    int c;
    longint ax, ay, az;
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dz = -1; dz <= 1; dz++) begin
          c = grid_index(kx + dx, ky + dy, kz + dz);
          if (c >= 0) begin
            for (int s = 0; s < fill[c]; s++) begin
              ax = absval(x - slot_x[c*Slots+s]);
              ay = absval(y - slot_y[c*Slots+s]);
              az = absval(z - slot_z[c*Slots+s]);
              if (ax <= voxel_mm && ay <= voxel_mm && az <= voxel_mm &&
                  ax*ax + ay*ay + az*az <= voxel_mm*voxel_mm) return 1'b1;
            end
          end
        end
    return 1'b0;
  endfunction

  function automatic bit occupied_around(longint kx, longint ky, longint kz, longint h);
    int c;
    for (longint dx = -h; dx <= h; dx++)
      for (longint dy = -h; dy <= h; dy++)
        for (longint dz = -h; dz <= h; dz++) begin
          c = grid_index(kx + dx, ky + dy, kz + dz);
          if (c >= 0 && occupied[c]) return 1'b1;
        end
    return 1'b0;
  endfunction

  function automatic verdict_t classify_or_insert(logic mode, longint x, longint y,
                                                  longint z, logic cv, logic eos);
    verdict_t v;
    longint kx, ky, kz, h;
    int c;
    kx = to_cell(x);
    ky = to_cell(y);
    kz = to_cell(z);
    v = '0;
    if (!mode) begin
      v.status = StatNone;
      if (cv) begin
        c = grid_index(kx, ky, kz);
        if (c < 0) begin
          v.status = StatOutside;
        end else begin
          occupied[c] = 1'b1;
          map_nonempty = 1'b1;
          if (fill[c] < Slots) begin
            slot_x[c*Slots+fill[c]] = x;
            slot_y[c*Slots+fill[c]] = y;
            slot_z[c*Slots+fill[c]] = z;
            fill[c]++;
            v.status = StatStored;
          end else begin
            v.status = StatFull;
          end
        end
      end
      return v;
    end
    v.keep = 1'b1;
    if (cv && map_nonempty && !static_match(x, y, z, kx, ky, kz)) begin
      h = (radius_mm * inv_scaled + (64'd1 << FracBits) - 1) >> FracBits;
      if (h < 2) h = 2;
      if (h > MaxHalf) h = MaxHalf;
      if (occupied_around(kx, ky, kz, h)) begin
        v.keep = 1'b0;
        if (scan_drops != 32'hFFFF_FFFF) scan_drops++;
      end
    end
    v.drops = scan_drops;
    v.status = StatNone;
    v.done = eos;
    if (eos) scan_drops = '0;
    return v;
  endfunction

  initial begin
    voxel_mm = 100;
    inv_scaled = 167772;
    radius_mm = 500;
    org_x = -16;
    org_y = -16;
    org_z = -16;
    map_nonempty = 1'b0;
    scan_drops = '0;
    fail_count = 0;
    words_pending = 0;
    for (int i = 0; i < Dim*Dim*Dim; i++) begin
      occupied[i] = 1'b0;
      fill[i] = 0;
    end
  end

  always @(posedge clk_i) begin
    verdict_t want, got;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegVoxel:   voxel_mm = longint'(pwdata[15:0]);
          RegInv:     inv_scaled = longint'(pwdata[24:0]);
          RegRadius:  radius_mm = longint'(pwdata[15:0]);
          RegOriginX: org_x = longint'(signed'(pwdata[23:0]));
          RegOriginY: org_y = longint'(signed'(pwdata[23:0]));
          RegOriginZ: org_z = longint'(signed'(pwdata[23:0]));
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        want = classify_or_insert(in_mon.mode, longint'(in_mon.pos_x),
                                  longint'(in_mon.pos_y),
                                  longint'(in_mon.pos_z),
                                  in_mon.coords_valid, in_mon.end_of_scan);
        verdict_q = {verdict_q, want};
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.keep_point, out_mon.drops_in_scan, out_mon.insert_status,
               out_mon.scan_done};
        if (verdict_q.size() == 0) begin
          $display("%0t: result word with nothing expected: keep=%0d drops=%0d",
                   $time, got.keep, got.drops);
          $display("%0t: unexpected word status=%0d done=%0d", $time, got.status, got.done);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (got.keep !== want.keep) begin
            $display("%0t: keep_point expected %0d actual %0d", $time, want.keep, got.keep);
            fail_count++;
          end
          if (got.drops !== want.drops) begin
            $display("%0t: drops_in_scan expected %0d actual %0d", $time, want.drops,
                     got.drops);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: insert_status expected %0d actual %0d", $time, want.status,
                     got.status);
            fail_count++;
          end
          if (got.done !== want.done) begin
            $display("%0t: scan_done expected %0d actual %0d", $time, want.done, got.done);
            fail_count++;
          end
        end
      end
      words_pending = verdict_q.size();
    end
  end

endmodule

// ===== tb/voxel_map_dynamic_point_filter_unit_test.sv =====
`timescale 1ns / 1ps
module voxel_map_dynamic_point_filter_unit_test;
  import vmdpf_pkg::*;

  localparam int NumSettings = 6;
  localparam int IdleLimit = 200000;
  localparam int SettleCycles = 7500;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          fail_count, words_pending;
  int          idle_cycles;
  int          inserts_sent, classifies_sent;
  bit          gaps_on, stalls_on, long_hold;
  longint      set_voxel, set_inv, set_radius, set_ox, set_oy, set_oz;
  longint      recent_x[$], recent_y[$], recent_z[$];

  vmdpf_in_if #(.CoordBits(24)) in_bus ();
  vmdpf_out_if out_bus ();

  voxel_map_dynamic_point_filter_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_bus), .out_if(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  voxel_map_dynamic_point_filter_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_bus), .out_mon(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
    .words_pending(words_pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d cycles without a handshake.", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      if (long_hold) begin
        out_bus.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input longint value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_word(input logic mode, input longint x, input longint y,
                           input longint z, input logic cv, input logic eos);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.mode         <= mode;
    in_bus.pos_x        <= x[23:0];
    in_bus.pos_y        <= y[23:0];
    in_bus.pos_z        <= z[23:0];
    in_bus.coords_valid <= cv;
    in_bus.end_of_scan  <= eos;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (mode) classifies_sent++;
    else inserts_sent++;
    if (!mode && cv) begin
      recent_x = {recent_x, x};
      recent_y = {recent_y, y};
      recent_z = {recent_z, z};
      if (recent_x.size() > 32) begin
        void'(recent_x.pop_front());
        void'(recent_y.pop_front());
        void'(recent_z.pop_front());
      end
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  function automatic longint grid_coord(longint org);
    return (org + $urandom_range(0, 35) - 2) * set_voxel + $urandom_range(0, set_voxel - 1);
  endfunction

  function automatic longint jitter(longint p);
    longint span;
    span = set_voxel + 1;
    return p + longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_word();
    int pick, j;
    logic cv, eos;
    pick = $urandom_range(0, 99);
    cv = ($urandom_range(0, 15) != 0);
    eos = ($urandom_range(0, 15) == 0);
    if (pick < 10) begin
      send_word(1'($urandom_range(0, 1)), longint'($urandom), longint'($urandom),
                longint'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 45) begin
      send_word(1'b0, grid_coord(set_ox), grid_coord(set_oy), grid_coord(set_oz), cv, eos);
    end else if (pick < 75 && recent_x.size() > 0) begin
      j = $urandom_range(0, recent_x.size() - 1);
      send_word(1'b1, jitter(recent_x[j]), jitter(recent_y[j]), jitter(recent_z[j]),
                cv, eos);
    end else begin
      send_word(1'b1, grid_coord(set_ox), grid_coord(set_oy), grid_coord(set_oz), cv, eos);
    end
  endtask

  initial begin
    longint settings[NumSettings][7];
    settings = '{
      '{100,   167772,   500,   -16,      -16,      -16, 450},
      '{1,     16777216, 0,     0,        0,        0,   200},
      '{65535, 256,      65535, -3,       -3,       -3,  150},
      '{250,   67108,    2000,  -20,      -10,      -5,  150},
      '{7,     1,        1,     -1,       -1,       -1,  100},
      '{1,     16777216, 3,     8388607,  -8388608, 4,   300}
    };
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.mode = 1'b0;
    in_bus.pos_x = '0;
    in_bus.pos_y = '0;
    in_bus.pos_z = '0;
    in_bus.coords_valid = 1'b0;
    in_bus.end_of_scan = 1'b0;
    idle_cycles = 0;
    inserts_sent = 0;
    classifies_sent = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    long_hold = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NumSettings; p++) begin
      if (p > 0) begin
        wait_drained();
        repeat (SettleCycles) @(posedge clk_i);
      end
      set_voxel = settings[p][0];
      set_inv = settings[p][1];
      set_radius = settings[p][2];
      set_ox = settings[p][3];
      set_oy = settings[p][4];
      set_oz = settings[p][5];
      write_reg(RegVoxel, set_voxel);
      write_reg(RegInv, set_inv);
      write_reg(RegRadius, set_radius);
      write_reg(RegOriginX, set_ox);
      write_reg(RegOriginY, set_oy);
      write_reg(RegOriginZ, set_oz);
      gaps_on = (p < NumSettings - 1);
      stalls_on = (p < NumSettings - 1);
      if (p == 0) begin
        send_word(1'b1, 0, 0, 0, 1'b1, 1'b0);
        send_word(1'b0, 0, 0, 0, 1'b0, 1'b0);
        send_word(1'b0, 8388607, 8388607, 8388607, 1'b1, 1'b0);
        send_word(1'b0, -8388608, -8388608, -8388608, 1'b1, 1'b0);
        send_word(1'b0, 1599, -1600, 0, 1'b1, 1'b0);
        repeat (5) send_word(1'b0, 50, 50, 50, 1'b1, 1'b0);
        send_word(1'b0, -1600, -1600, -1600, 1'b1, 1'b1);
        send_word(1'b1, 60, 60, 60, 1'b1, 1'b0);
        send_word(1'b1, 450, 50, 50, 1'b1, 1'b0);
        send_word(1'b1, 450, 450, 50, 1'b1, 1'b1);
        send_word(1'b1, 1500, 1500, 1500, 1'b1, 1'b0);
        send_word(1'b1, 450, 50, 50, 1'b0, 1'b1);
        send_word(1'b1, -1700, -1650, -1600, 1'b1, 1'b0);
        send_word(1'b1, 1650, 1599, 1599, 1'b1, 1'b0);
        send_word(1'b1, 8388607, -8388608, 8388607, 1'b1, 1'b1);
        send_word(1'b1, -8388608, 8388607, -8388608, 1'b1, 1'b0);
      end
      for (int i = 0; i < settings[p][6]; i++) begin
        if (p == 1 && i == 20) long_hold = 1'b1;
        if (p == 2 && i == 50) wait_drained();
        random_word();
      end
    end
    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("Run covered %0d map inserts and %0d scan classifications over %0d register settings,",
             inserts_sent, classifies_sent, NumSettings);
    $display("including full cells, points outside the grid, and the saturated search range.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
